// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sliding window spread RTL.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SWMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define SWMS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/swms_pkg.sv -----
// Shared constants and types for the sliding window spread block.
// No dependencies.
package swms_pkg;

  localparam int unsigned WINDOW_MAX = 256;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEN_W      = 9;
  localparam int unsigned IDX_W      = $clog2(WINDOW_MAX);
  localparam int unsigned FILL_W     = $clog2(WINDOW_MAX + 1);

  // running minimum and maximum held by one cell
  typedef struct packed {
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
  } span_t;

endpackage

// ----- rtl/swms_cell.sv -----
// One cell of the min/max row: extends its neighbour's span by the new sample.
// Depends on swms_pkg.
module swms_cell
  import swms_pkg::*;
(
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  span_t               prev_i,
  output span_t               span_o
);

  span_t span_q;
  span_t span_d;

  always_comb begin
    span_d.lo = (sample_i < prev_i.lo) ? sample_i : prev_i.lo;
    span_d.hi = (sample_i > prev_i.hi) ? sample_i : prev_i.hi;
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      span_q <= span_d;
    end
  end

  assign span_o = span_q;

endmodule

// ----- rtl/swms_chain.sv -----
// Row of WINDOW_MAX cells; cell i holds min/max of the newest i+1 samples.
// Depends on swms_pkg and swms_cell.
module swms_chain
  import swms_pkg::*;
(
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [IDX_W-1:0]    sel_i,
  output span_t               sel_span_o
);

  span_t spans [WINDOW_MAX];
  span_t head;

  // cell 0 sees the sample itself as its neighbour, so it just loads it
  assign head.hi = sample_i;
  assign head.lo = sample_i;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      swms_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (shift_i),
        .sample_i (sample_i),
        .prev_i   (head),
        .span_o   (spans[i])
      );
    end else begin : g_body
      swms_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (shift_i),
        .sample_i (sample_i),
        .prev_i   (spans[i-1]),
        .span_o   (spans[i])
      );
    end
  end

  assign sel_span_o = spans[sel_i];

endmodule

// ----- rtl/sliding_window_max_spread.sv -----
// Sliding window peak-to-peak tracker, top level.
// Depends on swms_pkg, swms_chain and assert_macros.svh.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o): one word per sample, sample_i plus
//   last_i marking the final sample of a sequence.
// - Output channel (out_valid_o/out_ready_i): one word per sequence, sent for
//   the sample flagged last: best_spread_o is the largest max minus min over
//   all full windows, had_window_o says whether any window was full.
// - Config channel (cfg_valid_i/cfg_ready_o): window length, always ready.
//   Zero acts as 1, values above 256 act as 256.
// - Throughput: one sample per cycle unless a last sample is held (see Stall).
//   Each sample updates a row of 256 cells and enters stage 1, which reads
//   the selected cell, updates the best spread and moves results out.
// - Stall: the result waits in an output register while samples keep flowing;
//   only a further last sample is held back until the result is taken.
// - Reset: window length 1, sequence state and channels cleared, no results
//   pending. The sample row itself is not cleared; no sweep is needed.
`include "assert_macros.svh"

module sliding_window_max_spread
  import swms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] best_spread_o,
  output logic                had_window_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LEN_W-1:0]    cfg_window_length_i
);

  logic [LEN_W-1:0]    win_len_q;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [SAMPLE_W-1:0] best_q, best_d;
  logic                seen_q, seen_d;

  logic                s1_valid_q, s1_valid_d;
  logic                s1_last_q;
  logic                s1_full_q;
  logic [IDX_W-1:0]    s1_sel_q;

  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_best_q;
  logic                out_had_q;

  logic                accept;
  logic                s1_move;
  logic [FILL_W-1:0]   len_eff;
  logic [FILL_W-1:0]   fill_inc;
  logic                win_full;
  logic [IDX_W-1:0]    sel_idx;
  span_t               sel_span;
  logic [SAMPLE_W-1:0] spread;
  logic [SAMPLE_W-1:0] best_new;
  logic                seen_new;

  assign cfg_ready_o = 1'b1;

  // a last word in stage 1 waits while the previous result is unread
  assign s1_move    = s1_valid_q && !(s1_last_q && out_valid_q && !out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (win_len_q == '0) begin
      len_eff = FILL_W'(1);
    end else if (FILL_W'(win_len_q) > FILL_W'(WINDOW_MAX)) begin
      len_eff = FILL_W'(WINDOW_MAX);
    end else begin
      len_eff = FILL_W'(win_len_q);
    end
  end

  assign fill_inc = (fill_q == FILL_W'(WINDOW_MAX)) ? fill_q : fill_q + FILL_W'(1);
  assign win_full = fill_inc >= len_eff;
  assign sel_idx  = IDX_W'(len_eff - FILL_W'(1));
  assign fill_d   = last_i ? '0 : fill_inc;

  swms_chain u_chain (
    .clk_i      (clk_i),
    .shift_i    (accept),
    .sample_i   (sample_i),
    .sel_i      (s1_sel_q),
    .sel_span_o (sel_span)
  );

  assign spread = sel_span.hi - sel_span.lo;

  always_comb begin
    best_new = best_q;
    seen_new = seen_q;
    if (s1_full_q) begin
      seen_new = 1'b1;
      if (spread > best_q) begin
        best_new = spread;
      end
    end
  end

  always_comb begin
    best_d = best_q;
    seen_d = seen_q;
    if (s1_move) begin
      best_d = s1_last_q ? '0 : best_new;
      seen_d = s1_last_q ? 1'b0 : seen_new;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= LEN_W'(1);
      fill_q      <= '0;
      best_q      <= '0;
      seen_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_len_q <= cfg_window_length_i;
      end
      if (accept) begin
        fill_q <= fill_d;
      end
      best_q      <= best_d;
      seen_q      <= seen_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= last_i;
      s1_full_q <= win_full;
      s1_sel_q  <= sel_idx;
    end
    if (s1_move && s1_last_q) begin
      out_best_q <= best_new;
      out_had_q  <= seen_new;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_spread_o = out_best_q;
  assign had_window_o  = out_had_q;

  `SWMS_ASSERT(a_no_window_zero, out_valid_o && !had_window_o |-> best_spread_o == '0, "spread without a full window")
  `SWMS_ASSERT(a_last_clears_fill, accept && last_i |=> fill_q == '0, "fill count not cleared after last word")
  `SWMS_ASSERT_NEVER(a_fill_range, fill_q > FILL_W'(WINDOW_MAX), "fill count beyond window depth")
  `SWMS_ASSERT(a_hold_only_on_result, s1_valid_q && !in_ready_o |-> out_valid_q && s1_last_q, "input held without a pending result")

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for sliding_window_max_spread: a directed table, then random
// sequences, every result word checked against its pinned row or a predictor kept in this file.
// Depends on swms_pkg and the RTL of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swms_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef struct packed {
    logic [SAMPLE_W-1:0] spread;
    logic                had;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [SAMPLE_W-1:0] value;
    logic                last;
    bit                  pinned;
    result_t             want;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] sample_i = '0;
  logic                last_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SAMPLE_W-1:0] best_spread_o;
  logic                had_window_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LEN_W-1:0]    cfg_window_length_i = '0;

  sliding_window_max_spread i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sample_i           (sample_i),
    .last_i             (last_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .best_spread_o      (best_spread_o),
    .had_window_o       (had_window_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_window_length_i(cfg_window_length_i)
  );

  always #1 clk_i = ~clk_i;

  // directed table; a pinned row carries a result read straight off the rules
  row_t plan [26] = '{
    '{ROW_SAMPLE, 16'h0005, 1'b1, 1'b1, '{16'h0000, 1'b1}},  // length 1 after reset
    '{ROW_CFG,    16'd0,    1'b0, 1'b0, '{16'h0000, 1'b0}},  // zero acts as 1
    '{ROW_SAMPLE, 16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b1, '{16'h0000, 1'b1}},
    '{ROW_CFG,    16'd2,    1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b1}},  // widest spread
    '{ROW_CFG,    16'd3,    1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'h0007, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'h0009, 1'b1, 1'b1, '{16'h0000, 1'b0}},  // sequence shorter than window
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b1, '{16'h0000, 1'b0}},  // single-word sequence
    '{ROW_CFG,    16'd511,  1'b0, 1'b0, '{16'h0000, 1'b0}},  // saturates to 256
    '{ROW_SAMPLE, 16'h0001, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'h0002, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'h0003, 1'b1, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_CFG,    16'd3,    1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'hAAAA, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_CFG,    16'd2,    1'b0, 1'b0, '{16'h0000, 1'b0}},  // shrink mid-sequence
    '{ROW_SAMPLE, 16'h1234, 1'b1, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_CFG,    16'd4,    1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'd10,   1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'd40,   1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'd25,   1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{ROW_SAMPLE, 16'd40,   1'b0, 1'b0, '{16'h0000, 1'b0}},  // repeated maximum
    '{ROW_SAMPLE, 16'd10,   1'b1, 1'b0, '{16'h0000, 1'b0}}
  };

  // predictor state
  logic [SAMPLE_W-1:0] recent_samples [WINDOW_MAX];
  int unsigned         fill_seen = 0;
  logic [SAMPLE_W-1:0] top_spread = '0;
  logic                window_seen = 1'b0;
  logic [LEN_W-1:0]    span_setting = LEN_W'(1);

  result_t     pending_spreads [$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 79;
  int unsigned hold_tickets = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // shift a word into the window and score it; a last word yields the result
  function automatic bit advance_window(input logic [SAMPLE_W-1:0] s, input logic l,
                                        output result_t res);
    int unsigned         span;
    int unsigned         k;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    span = (span_setting == 0) ? 1 :
           ((span_setting > WINDOW_MAX) ? WINDOW_MAX : span_setting);
    for (k = WINDOW_MAX - 1; k > 0; k--) recent_samples[k] = recent_samples[k-1];
    recent_samples[0] = s;
    if (fill_seen < WINDOW_MAX) fill_seen++;
    if (fill_seen >= span) begin
      lo = recent_samples[0];
      hi = recent_samples[0];
      for (k = 1; k < span; k++) begin
        if (recent_samples[k] < lo) lo = recent_samples[k];
        if (recent_samples[k] > hi) hi = recent_samples[k];
      end
      if (hi - lo > top_spread) top_spread = hi - lo;
      window_seen = 1'b1;
    end
    res = '{top_spread, window_seen};
    if (!l) return 1'b0;
    fill_seen   = 0;
    top_spread  = '0;
    window_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(input int unsigned style);
    logic [SAMPLE_W-1:0] base;
    base = SAMPLE_W'($urandom_range(65535));
    case (style)
      0: return base;
      1: return base | SAMPLE_W'($urandom_range(15));
      2: return $urandom_range(1) ? '1 : '0;
      default: return SAMPLE_W'(16'h8000);
    endcase
  endfunction

  // called and returning at a falling edge
  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic l,
                             input bit pinned, input result_t pinned_res);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    if (advance_window(s, l, res)) pending_spreads.push_back(pinned ? pinned_res : res);
    @(negedge clk_i);
  endtask

  // drain every outstanding result, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_spreads.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] v);
    cfg_valid_i         <= 1'b1;
    cfg_window_length_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    span_setting = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // whole sequences, mostly long enough to fill the window
  task automatic run_traffic(input int unsigned n, input int unsigned span);
    int unsigned sent;
    int unsigned seq_len;
    int unsigned style;
    int unsigned pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(9);
      if (pick < 6) seq_len = $urandom_range(span + 6, span);
      else if (pick < 9) seq_len = $urandom_range(span, 1);
      else seq_len = 1;
      style = $urandom_range(3);
      for (int j = 0; j < seq_len; j++)
        push_sample(draw_sample(style), j == seq_len - 1, 1'b0, '0);
      sent += seq_len;
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_seen != hold_tickets) begin
      hold_seen = hold_tickets;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_spreads.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: spread %0d had_window %0b",
                 $time, best_spread_o, had_window_o);
      end else begin
        want = pending_spreads.pop_front();
        if (best_spread_o !== want.spread) begin
          errors++;
          $display("%0t: best_spread mismatch: expected %0d, got %0d",
                   $time, want.spread, best_spread_o);
        end
        if (had_window_o !== want.had) begin
          errors++;
          $display("%0t: had_window mismatch: expected %0b, got %0b",
                   $time, want.had, had_window_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_len(plan[i].value[LEN_W-1:0]);
      end else begin
        push_sample(plan[i].value, plan[i].last, plan[i].pinned, plan[i].want);
      end
    end

    settle();
    write_len(LEN_W'(1));
    run_traffic(40, 1);
    settle();
    write_len(LEN_W'(5));
    run_traffic(20, 5);
    hold_tickets++;  // long receiver stall while words keep coming
    run_traffic(40, 5);

    send_idle_pct = 79;
    recv_idle_pct = 21;
    settle();
    write_len(LEN_W'(WINDOW_MAX));
    for (int i = 0; i < 200; i++) push_sample(draw_sample($urandom_range(3)), 1'b0, 1'b0, '0);
    settle();
    write_len(LEN_W'(511));  // same window once saturated, changed mid-sequence
    for (int i = 0; i < 56; i++) push_sample(draw_sample($urandom_range(3)), 1'b0, 1'b0, '0);
    push_sample(draw_sample(0), 1'b1, 1'b0, '0);
    run_traffic(10, 4);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle();
    write_len(LEN_W'(3));
    run_traffic(20, 3);
    settle();  // sender pause until every result is back
    run_traffic(20, 3);
    settle();
    write_len(LEN_W'($urandom_range(12, 1)));
    run_traffic(40, 8);

    in_valid_i <= 1'b0;
    while (pending_spreads.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
